// ===== src/fcsm_pkg.sv =====
package fcsm_pkg;
    localparam int FRAC_BITS_DEF        = 16;
    localparam int NUM_VOICES_DEF       = 4;
    localparam int NUM_INSTRUMENTS_DEF  = 15;
    localparam int SAMPLE_ADDR_BITS_DEF = 16;

    localparam logic [22:0] PAULA_CLOCK = 23'd7159092;
    localparam logic [15:0] NOTE_MARK   = 16'hFFFD;
    localparam logic [15:0] NOTE_STOP   = 16'hFFFE;
    localparam logic [15:0] PERIOD_MIN  = 16'h0037;
    localparam logic [15:0] PERIOD_END  = 16'h1000;
    localparam logic [6:0]  VOL_MAX     = 7'h3F;
    localparam logic [15:0] RATE_RESET  = 16'd22050;
    localparam logic [3:0]  EFF_VOL_UP  = 4'd5;
    localparam logic [3:0]  EFF_VOL_DN  = 4'd6;

    localparam logic [1:0] ACT_BYTE  = 2'd0;
    localparam logic [1:0] ACT_INSTR = 2'd1;
    localparam logic [1:0] ACT_NOTE  = 2'd2;
    localparam logic [1:0] ACT_FRAME = 2'd3;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] mem_address;
        logic [7:0]  mem_byte;
        logic [3:0]  instrument_slot;
        logic [15:0] instrument_base;
        logic [6:0]  instrument_level;
        logic        instrument_present;
        logic [1:0]  voice;
        logic [15:0] note_word;
        logic [15:0] effect_word;
    } t_in_item;

    typedef struct packed {
        logic signed [7:0] left_sample;
        logic signed [7:0] right_sample;
        logic              mark_valid;
        logic [15:0]       mark_value;
    } t_out_item;

    typedef struct packed {
        logic        start;
        logic [39:0] dividend;
        logic [23:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [39:0] quotient;
    } t_div_rsp;
endpackage

// ===== src/fcsm_if.sv =====
interface fcsm_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== src/fcsm_ram.sv =====
module fcsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== src/fcsm_div.sv =====
// Restoring divider, one quotient bit per cycle.
module fcsm_div
    import fcsm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);
    logic [39:0] r_quo;
    logic [24:0] r_rem;
    logic [5:0]  r_cnt;
    logic        r_busy, r_done;
    logic [23:0] r_dvs;
    logic [24:0] trial;
    logic [24:0] diff;

    assign trial = {r_rem[23:0], r_quo[39]};
    assign diff  = trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd40;
                r_quo  <= i_req.dividend;
                r_rem  <= '0;
                r_dvs  <= i_req.divisor;
            end else if (r_busy) begin
                if (!diff[24]) begin
                    r_rem <= diff;
                    r_quo <= {r_quo[38:0], 1'b1};
                end else begin
                    r_rem <= trial;
                    r_quo <= {r_quo[38:0], 1'b0};
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;
endmodule

// ===== src/four_channel_sample_mixer.sv =====
// Flow: a sample byte or instrument write goes straight to the output step; a note event
// that starts the note runs the divider twice in turn, period to frequency and then
// frequency to step; a frame visits every voice, mixes a playing one, skips a silent one
// and ends one that runs out, then filters; the result is then held until taken.
// Throughput: one item at a time; the input is not ready until the result is accepted.
// Reset (synchronous, active low): voices silent, instrument table absent, filter zero,
// output rate 22050. Sample memory is not cleared.
module four_channel_sample_mixer
    import fcsm_pkg::*;
#(
    parameter int FRAC_BITS        = FRAC_BITS_DEF,
    parameter int NUM_VOICES       = NUM_VOICES_DEF,
    parameter int NUM_INSTRUMENTS  = NUM_INSTRUMENTS_DEF,
    parameter int SAMPLE_ADDR_BITS = SAMPLE_ADDR_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    fcsm_if.sink        in_if,
    fcsm_if.source      out_if
);
    localparam int PW = 17 + FRAC_BITS;          // phase width
    localparam int AW = SAMPLE_ADDR_BITS;
    localparam int VW = $clog2(NUM_VOICES);

    // Sequencer states
    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_HDR0  = 5'd1;
    localparam logic [4:0] S_HDR1  = 5'd2;
    localparam logic [4:0] S_HDR2  = 5'd3;
    localparam logic [4:0] S_HDR3  = 5'd4;
    localparam logic [4:0] S_HDR4  = 5'd5;
    localparam logic [4:0] S_NOTE  = 5'd6;
    localparam logic [4:0] S_DIV1  = 5'd7;
    localparam logic [4:0] S_DIV2  = 5'd8;
    localparam logic [4:0] S_VSEL  = 5'd9;
    localparam logic [4:0] S_RDA   = 5'd10;
    localparam logic [4:0] S_RDB   = 5'd11;
    localparam logic [4:0] S_MUL1  = 5'd12;
    localparam logic [4:0] S_MUL2  = 5'd13;
    localparam logic [4:0] S_ACC   = 5'd14;
    localparam logic [4:0] S_FILT  = 5'd15;
    localparam logic [4:0] S_OUT   = 5'd16;
    localparam logic [4:0] S_WAIT1 = 5'd17;
    localparam logic [4:0] S_WAIT2 = 5'd18;
    localparam logic [4:0] S_DIVS  = 5'd19;

    logic [4:0]  r_state;
    t_in_item    r_item;
    logic [15:0] r_rate;

    // Instrument table: present bit, level, base
    logic        r_ins_ok  [NUM_INSTRUMENTS];
    logic [6:0]  r_ins_lvl [NUM_INSTRUMENTS];
    logic [15:0] r_ins_base[NUM_INSTRUMENTS];

    logic [AW-1:0] r_vstart [NUM_VOICES];
    logic [16:0]   r_vlen   [NUM_VOICES];
    logic [16:0]   r_vlpos  [NUM_VOICES];
    logic [16:0]   r_vllen  [NUM_VOICES];
    logic [6:0]    r_vvol   [NUM_VOICES];
    logic [PW-1:0] r_vphase [NUM_VOICES];
    logic [31:0]   r_vstep  [NUM_VOICES];

    logic signed [7:0] r_prev_l, r_prev_r;

    // Header fetch scratch
    logic [15:0] r_base;
    logic [16:0] r_len, r_llen;
    logic [7:0]  r_hi;
    logic        r_prep;
    logic [15:0] r_freq;

    // Mixer scratch
    logic [1:0]         r_slot;          // index into voice order 0,3,1,2
    logic [VW-1:0]      r_v;
    logic [16:0]        r_pos1, r_pos2;
    logic [FRAC_BITS-1:0] r_frac;
    logic signed [7:0]  r_a;
    logic signed [31:0] r_prod;
    logic signed [15:0] r_interp;
    logic signed [8:0]  r_acc;
    logic signed [7:0]  r_left;
    logic               r_skip;

    t_out_item r_out;
    logic      r_out_valid;

    // Sample memory
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]    ram_wdata, ram_rdata;

    fcsm_ram #(.WIDTH(8), .DEPTH(1 << AW)) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    t_div_req div_req;
    t_div_rsp div_rsp;
    fcsm_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(div_req), .o_rsp(div_rsp));

    assign in_if.ready    = (r_state == S_IDLE) && !r_out_valid;
    assign out_if.valid   = r_out_valid;
    assign out_if.payload = r_out;

    logic in_acc;
    assign in_acc = in_if.valid && in_if.ready;

    // Instrument lookup for the current note event
    logic [3:0] inst_num;
    logic       inst_ok;
    logic [3:0] inst_idx;
    assign inst_num = r_item.effect_word[15:12];
    assign inst_idx = inst_num - 4'd1;
    assign inst_ok  = (inst_num != 4'd0) && ({28'd0, inst_idx} < NUM_INSTRUMENTS)
                      && r_ins_ok[inst_idx[$clog2(NUM_INSTRUMENTS+1)-1:0]];

    // Voice visiting order: 0, 3 left; 1, 2 right
    logic [VW-1:0] slot_voice;
    always_comb begin
        case (r_slot)
            2'd0:    slot_voice = VW'(0);
            2'd1:    slot_voice = VW'(3);
            2'd2:    slot_voice = VW'(1);
            default: slot_voice = VW'(2);
        endcase
    end

    // Read address of the sample memory
    logic [17:0] last_pos;
    always_comb begin
        ram_raddr = '0;
        case (r_state)
            S_HDR0:  ram_raddr = AW'(r_base);
            S_HDR1:  ram_raddr = AW'(r_base) + AW'(1);
            S_HDR2:  ram_raddr = AW'(r_base) + AW'(2);
            S_HDR3:  ram_raddr = AW'(r_base) + AW'(3);
            S_RDA:   ram_raddr = r_vstart[r_v] + AW'(r_pos1);
            S_RDB:   ram_raddr = r_vstart[r_v] + AW'(r_pos2);
            default: ram_raddr = '0;
        endcase
    end
    assign ram_we    = in_acc && (in_if.payload.action == ACT_BYTE);
    assign ram_waddr = AW'(in_if.payload.mem_address);
    assign ram_wdata = in_if.payload.mem_byte;
    // Last loop position can pass 17 bits: keep the carry
    assign last_pos  = {1'b0, r_vlpos[r_v]} + {1'b0, r_vllen[r_v]} - 18'd1;

    // Shared multiplier input
    logic signed [17:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [35:0] mul_p;
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_MUL1:  begin
                mul_a = 18'(r_a);
                mul_b = 18'sd1 <<< FRAC_BITS;
                mul_b = mul_b - $signed({1'b0, 17'(r_frac)});
            end
            S_MUL2:  begin
                mul_a = 18'(r_a);
                mul_b = $signed({1'b0, 17'(r_frac)});
            end
            S_ACC:   begin
                mul_a = 18'(r_interp);
                mul_b = $signed({11'd0, r_vvol[r_v]});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // Half-sum filter helpers
    logic signed [7:0] half_acc;
    logic [8:0]        biased;
    assign biased   = 9'(r_acc) + 9'd128;
    assign half_acc = $signed(8'(biased[8:1])) - 8'sd64;

    // Right side total lands in r_acc, left in r_left
    logic signed [7:0] hl_f, hr_f;
    logic [8:0] bl;
    assign bl   = 9'({r_left[7], r_left}) + 9'd128;
    assign hl_f = $signed(8'(bl[8:1])) - 8'sd64;
    assign hr_f = half_acc;

    // Saturating add of a scaled voice value (truncating divide by 64)
    logic signed [35:0] scaled_full;
    logic signed [15:0] scaled;
    logic signed [16:0] sum;
    logic signed [8:0]  acc_next;
    assign scaled_full = (mul_p + ((mul_p < 0) ? 36'sd63 : 36'sd0)) >>> 6;
    assign scaled      = 16'(scaled_full);
    assign sum         = 17'(r_acc) + 17'(scaled);
    always_comb begin
        if (r_skip)                 acc_next = r_acc;
        else if (sum < -17'sd128)   acc_next = -9'sd128;
        else if (sum > 17'sd127)    acc_next = 9'sd127;
        else                        acc_next = 9'(sum);
    end

    // Volume computation
    logic signed [9:0] vol_calc;
    always_comb begin
        vol_calc = $signed({3'd0, r_ins_lvl[inst_idx[$clog2(NUM_INSTRUMENTS+1)-1:0]]});
        if (r_item.effect_word[11:8] == EFF_VOL_UP) begin
            vol_calc = vol_calc + $signed({2'd0, r_item.effect_word[7:0]});
            if (vol_calc > 10'sd63) vol_calc = 10'sd63;
        end else if (r_item.effect_word[11:8] == EFF_VOL_DN) begin
            vol_calc = vol_calc - $signed({2'd0, r_item.effect_word[7:0]});
            if (vol_calc < 10'sd0) vol_calc = 10'sd0;
        end
    end

    logic [PW-1:0] phase_adv;
    assign phase_adv = r_vphase[r_v] + PW'(r_vstep[r_v]);

    always_comb begin
        div_req = '0;
        if (r_state == S_DIV1) begin
            div_req.start    = 1'b1;
            div_req.dividend = 40'(PAULA_CLOCK);
            div_req.divisor  = 24'({r_item.note_word, 1'b0});
        end else if (r_state == S_DIVS) begin
            div_req.start    = 1'b1;
            div_req.dividend = 40'(r_freq) << FRAC_BITS;
            div_req.divisor  = (r_rate == 16'd0) ? 24'd1 : 24'(r_rate);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_rate      <= RATE_RESET;
            r_prev_l    <= '0;
            r_prev_r    <= '0;
            for (int i = 0; i < NUM_INSTRUMENTS; i++) begin
                r_ins_ok[i]   <= 1'b0;
                r_ins_lvl[i]  <= '0;
                r_ins_base[i] <= '0;
            end
            for (int i = 0; i < NUM_VOICES; i++) begin
                r_vstart[i] <= '0;
                r_vlen[i]   <= '0;
                r_vlpos[i]  <= '0;
                r_vllen[i]  <= '0;
                r_vvol[i]   <= '0;
                r_vphase[i] <= '0;
                r_vstep[i]  <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_rate <= i_cfg_wdata;
            end
            if (out_if.valid && out_if.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_item <= in_if.payload;
                        r_out  <= '0;
                        case (in_if.payload.action)
                            ACT_BYTE:  r_state <= S_OUT;
                            ACT_INSTR: begin
                                // Drop writes to slots beyond the table
                                if ({28'd0, in_if.payload.instrument_slot} < NUM_INSTRUMENTS)
                                begin
                                    r_ins_ok[in_if.payload.instrument_slot]  <=
                                        in_if.payload.instrument_present;
                                    r_ins_lvl[in_if.payload.instrument_slot] <=
                                        (in_if.payload.instrument_level > 7'd64) ? 7'd64 :
                                        in_if.payload.instrument_level;
                                    r_ins_base[in_if.payload.instrument_slot] <=
                                        in_if.payload.instrument_base;
                                end
                                r_state <= S_OUT;
                            end
                            ACT_NOTE:  r_state <= S_NOTE;
                            default: begin
                                r_slot  <= 2'd0;
                                r_acc   <= '0;
                                r_state <= S_VSEL;
                            end
                        endcase
                    end
                end
                S_NOTE: begin
                    r_prep <= 1'b0;
                    if (r_item.note_word == NOTE_MARK) begin
                        r_out.mark_valid <= 1'b1;
                        r_out.mark_value <= r_item.effect_word;
                        r_state          <= S_OUT;
                    end else if (inst_ok) begin
                        r_base  <= r_ins_base[inst_idx[$clog2(NUM_INSTRUMENTS+1)-1:0]];
                        r_vvol[r_item.voice[VW-1:0]] <= 7'(vol_calc);
                        r_prep  <= 1'b1;
                        r_state <= S_HDR0;
                    end else begin
                        r_state <= S_WAIT1;
                    end
                end
                // Fetch the header: length and loop length, big endian words
                S_HDR0: r_state <= S_HDR1;
                S_HDR1: begin
                    r_hi    <= ram_rdata;
                    r_state <= S_HDR2;
                end
                S_HDR2: begin
                    r_len   <= {r_hi, ram_rdata, 1'b0};
                    r_state <= S_HDR3;
                end
                S_HDR3: begin
                    r_hi    <= ram_rdata;
                    r_state <= S_HDR4;
                end
                S_HDR4: begin
                    r_llen  <= {r_hi, ram_rdata, 1'b0};
                    r_state <= S_WAIT1;
                end
                S_WAIT1: begin
                    if (r_item.note_word == NOTE_STOP) begin
                        r_vlen[r_item.voice[VW-1:0]] <= '0;
                        r_state <= S_OUT;
                    end else if (r_prep && r_item.note_word >= PERIOD_MIN &&
                                 r_item.note_word < PERIOD_END) begin
                        r_state <= S_DIV1;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_DIV1: r_state <= S_WAIT2;
                S_WAIT2: begin
                    if (div_rsp.done) begin
                        r_freq  <= div_rsp.quotient[15:0];
                        r_state <= S_DIVS;
                    end
                end
                S_DIVS: r_state <= S_DIV2;
                S_DIV2: begin
                    if (div_rsp.done) begin
                        r_vstart[r_item.voice[VW-1:0]] <= AW'(r_base) + AW'(8);
                        r_vlen[r_item.voice[VW-1:0]]   <= r_len;
                        r_vlpos[r_item.voice[VW-1:0]]  <= (r_llen != 17'd0) ? r_len : 17'd0;
                        r_vllen[r_item.voice[VW-1:0]]  <= r_llen;
                        r_vphase[r_item.voice[VW-1:0]] <= '0;
                        r_vstep[r_item.voice[VW-1:0]]  <= div_rsp.quotient[31:0];
                        r_state <= S_OUT;
                    end
                end
                // Mixer: advance one voice per pass
                S_VSEL: begin
                    r_v     <= slot_voice;
                    r_skip  <= 1'b0;
                    r_state <= S_RDA;
                    if (r_vlen[slot_voice] == 17'd0) begin
                        r_skip  <= 1'b1;
                        r_state <= S_ACC;
                    end else begin
                        r_pos1 <= 17'(r_vphase[slot_voice] >> FRAC_BITS);
                    end
                end
                S_RDA: begin
                    // Wrap or end the voice, settle the next phase
                    r_vphase[r_v] <= phase_adv;
                    r_pos2        <= r_pos1 + 17'd1;
                    r_frac        <= phase_adv[FRAC_BITS-1:0];
                    if (r_vllen[r_v] != 17'd0) begin
                        if ({1'b0, r_pos1} >= last_pos) begin
                            r_pos2        <= r_vlpos[r_v];
                            r_vphase[r_v] <= PW'(r_vlpos[r_v]) << FRAC_BITS;
                            r_frac        <= '0;
                        end
                        r_state <= S_RDB;
                    end else if (r_pos1 >= r_vlen[r_v] - 17'd1) begin
                        r_vlen[r_v] <= '0;
                        r_skip      <= 1'b1;
                        r_state     <= S_ACC;
                    end else begin
                        r_state <= S_RDB;
                    end
                end
                S_RDB: begin
                    // Data for pos1 arrives now; pos2 read is in flight
                    r_a     <= $signed(ram_rdata);
                    r_state <= S_MUL1;
                end
                S_MUL1: begin
                    // Weight pos1 by the remaining fraction, take the pos2 data
                    r_prod  <= 32'(mul_p);
                    r_a     <= $signed(ram_rdata);
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_prod  <= r_prod + 32'(mul_p);
                    r_state <= S_FILT;
                end
                S_FILT: begin
                    // Floor shift of the interpolated value
                    r_interp <= 16'(r_prod >>> FRAC_BITS);
                    r_state  <= S_ACC;
                end
                S_ACC: begin
                    // Close the left side after voice 3; the right side ends after voice 2
                    if (r_slot == 2'd1) begin
                        r_left <= 8'(acc_next);
                        r_acc  <= '0;
                    end else begin
                        r_acc  <= acc_next;
                    end
                    r_slot  <= r_slot + 2'd1;
                    r_state <= (r_slot == 2'd3) ? S_OUT : S_VSEL;
                end
                S_OUT: begin
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
            if (r_state == S_OUT && r_item.action == ACT_FRAME) begin
                r_out.left_sample  <= hl_f + r_prev_l;
                r_out.right_sample <= hr_f + r_prev_r;
                r_prev_l           <= hl_f;
                r_prev_r           <= hr_f;
            end
        end
    end
endmodule

// ===== src/fcsm_checker.sv =====
module fcsm_checker
    import fcsm_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input t_out_item out_payload
);
    // No new item while a result waits
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> !in_ready) else $error("input taken while result pending");
    // Result waits until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_payload))
        else $error("result dropped");
    // Ready falls right after an item is accepted
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> !in_ready) else $error("ready held after accept");
endmodule

bind four_channel_sample_mixer fcsm_checker u_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .in_valid   (in_if.valid),
    .in_ready   (in_if.ready),
    .out_valid  (out_if.valid),
    .out_ready  (out_if.ready),
    .out_payload(out_if.payload)
);

// ===== bench/fcsm_mix_checker.sv =====
module fcsm_mix_checker
    import fcsm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  t_in_item    i_req,
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  t_out_item   i_res,
    output int          o_fail_count,
    output int          o_pending
);
    localparam int     FRAC       = FRAC_BITS_DEF;
    localparam int     NVOICE     = NUM_VOICES_DEF;
    localparam int     NINSTR     = NUM_INSTRUMENTS_DEF;
    localparam longint ADDR_MASK  = (64'd1 << SAMPLE_ADDR_BITS_DEF) - 1;
    localparam longint PHASE_MASK = (64'd1 << (17 + FRAC)) - 1;
    localparam longint FRAC_ONE   = 64'd1 << FRAC;

    typedef struct {
        longint base;
        longint level;
        bit     present;
    } t_instr_entry;

    logic [7:0]   sample_mem [0:(1 << SAMPLE_ADDR_BITS_DEF) - 1];
    t_instr_entry instr_tab [NINSTR];
    longint       v_start [NVOICE];
    longint       v_len [NVOICE];
    longint       v_loop_start [NVOICE];
    longint       v_loop_len [NVOICE];
    longint       v_vol [NVOICE];
    longint       v_phase [NVOICE];
    longint       v_step [NVOICE];
    int           prev_left;
    int           prev_right;
    longint       out_rate;
    t_out_item    pending_results[$];
    int           fails;

    function automatic longint sample_at(longint addr);
        return longint'($signed(sample_mem[addr & ADDR_MASK]));
    endfunction

    function automatic longint word_at(longint addr);
        return (longint'(sample_mem[addr & ADDR_MASK]) << 8)
             | longint'(sample_mem[(addr + 1) & ADDR_MASK]);
    endfunction

    // advance one voice by one frame and add its scaled value to the side's sum
    function automatic int mix_voice(int acc, int v);
        longint pos1, pos2, last, frac, interp;
        int     sum;
        if (v_len[v] == 0) return acc;
        pos1 = v_phase[v] >> FRAC;
        v_phase[v] = (v_phase[v] + v_step[v]) & PHASE_MASK;
        pos2 = pos1 + 1;
        if (v_loop_len[v] != 0) begin
            last = v_loop_start[v] + v_loop_len[v] - 1;
            if (pos1 >= last) begin
                pos2 = v_loop_start[v];
                v_phase[v] = (pos2 << FRAC) & PHASE_MASK;
            end
        end else if (pos1 >= v_len[v] - 1) begin
            v_len[v] = 0;
            return acc;
        end
        frac = v_phase[v] & (FRAC_ONE - 1);
        interp = sample_at(v_start[v] + pos1) * (FRAC_ONE - frac)
               + sample_at(v_start[v] + pos2) * frac;
        interp = interp >>> FRAC;
        sum = acc + int'((interp * v_vol[v]) / 64);
        if (sum < -128) sum = -128;
        if (sum > 127) sum = 127;
        return sum;
    endfunction

    function automatic t_out_item predict_result(t_in_item it);
        t_out_item r;
        int        v, left, right, hl, hr;
        longint    inst, m, base, len, ll, loop_pos, loop_len, freq, div;
        bit        prepared;
        r = '0;
        prepared = 0;
        base = 0;
        len = 0;
        loop_pos = 0;
        loop_len = 0;
        case (it.action)
            ACT_BYTE: begin
                sample_mem[it.mem_address & ADDR_MASK] = it.mem_byte;
            end
            ACT_INSTR: begin
                if (it.instrument_slot < NINSTR) begin
                    instr_tab[it.instrument_slot].base    = it.instrument_base;
                    instr_tab[it.instrument_slot].level   =
                        (it.instrument_level > 64) ? 64 : it.instrument_level;
                    instr_tab[it.instrument_slot].present = it.instrument_present;
                end
            end
            ACT_NOTE: begin
                v = it.voice;
                if (it.note_word != NOTE_MARK) begin
                    inst = it.effect_word[15:12];
                    if (inst != 0 && inst - 1 < NINSTR && instr_tab[inst - 1].present) begin
                        m = instr_tab[inst - 1].level;
                        base = instr_tab[inst - 1].base;
                        len = word_at(base) * 2;
                        ll = word_at(base + 2) * 2;
                        if (ll != 0) begin
                            loop_pos = len;
                            loop_len = ll;
                        end
                        if (it.effect_word[11:8] == EFF_VOL_UP) begin
                            m += it.effect_word[7:0];
                            if (m > VOL_MAX) m = VOL_MAX;
                        end else if (it.effect_word[11:8] == EFF_VOL_DN) begin
                            m -= it.effect_word[7:0];
                            if (m < 0) m = 0;
                        end
                        v_vol[v] = m;
                        prepared = 1;
                    end
                end
                if (it.note_word == NOTE_MARK) begin
                    r.mark_valid = 1'b1;
                    r.mark_value = it.effect_word;
                end else if (it.note_word == NOTE_STOP) begin
                    v_len[v] = 0;
                end else if (it.note_word != 0 && prepared && it.note_word >= PERIOD_MIN
                             && it.note_word < PERIOD_END) begin
                    freq = (longint'(PAULA_CLOCK) / (longint'(it.note_word) * 2)) & 16'hFFFF;
                    div = (out_rate != 0) ? out_rate : 1;
                    v_start[v] = (base + 8) & ADDR_MASK;
                    v_len[v] = len;
                    v_loop_start[v] = loop_pos;
                    v_loop_len[v] = loop_len;
                    v_phase[v] = 0;
                    v_step[v] = ((freq << FRAC) / div) & 32'hFFFF_FFFF;
                end
            end
            default: begin
                // voices 0 and 3 feed the left side, 1 and 2 the right
                left = mix_voice(0, 0);
                left = mix_voice(left, 3);
                right = mix_voice(0, 1);
                right = mix_voice(right, 2);
                hl = left >>> 1;
                hr = right >>> 1;
                r.left_sample = 8'(hl + prev_left);
                r.right_sample = 8'(hr + prev_right);
                prev_left = hl;
                prev_right = hr;
            end
        endcase
        return r;
    endfunction

    task automatic report_failure(string what, t_out_item want, t_out_item got);
        fails++;
        if (fails <= 10)
            $display("%0t: %s: expected L=%0d R=%0d mark=%0b/%h, got L=%0d R=%0d mark=%0b/%h",
                     $realtime, what, want.left_sample, want.right_sample, want.mark_valid,
                     want.mark_value, got.left_sample, got.right_sample, got.mark_valid,
                     got.mark_value);
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            // sample memory survives reset, everything else clears
            foreach (instr_tab[k]) instr_tab[k] = '{0, 0, 0};
            for (int k = 0; k < NVOICE; k++) begin
                v_start[k] = 0;
                v_len[k] = 0;
                v_loop_start[k] = 0;
                v_loop_len[k] = 0;
                v_vol[k] = 0;
                v_phase[k] = 0;
                v_step[k] = 0;
            end
            prev_left = 0;
            prev_right = 0;
            out_rate = RATE_RESET;
            pending_results.delete();
        end else begin
            if (i_cfg_we) out_rate = i_cfg_wdata;
            if (i_res_valid && i_res_ready) begin
                if (pending_results.size() == 0) begin
                    report_failure("unexpected item", '0, i_res);
                end else begin
                    want = pending_results.pop_front();
                    if (want.left_sample !== i_res.left_sample
                        || want.right_sample !== i_res.right_sample
                        || want.mark_valid !== i_res.mark_valid
                        || want.mark_value !== i_res.mark_value)
                        report_failure("mismatch", want, i_res);
                end
            end
            if (i_req_valid && i_req_ready)
                pending_results.push_back(predict_result(i_req));
        end
        o_fail_count <= fails;
        o_pending <= pending_results.size();
    end

    initial fails = 0;
endmodule

// ===== bench/four_channel_sample_mixer_test.sv =====
module four_channel_sample_mixer_test;
    import fcsm_pkg::*;

    // Each instrument's header and data live in a fixed block; every read a playing voice
    // can make (header, data, loop overshoot of up to one step) stays inside the block.
    localparam int BLOCK_SPAN = 48;
    localparam int NUM_BLOCKS = 8;
    localparam int DATA_FIRST = 8;
    localparam int REGION_END = BLOCK_SPAN * NUM_BLOCKS;
    // settle time before a register write or the verdict: covers two divisions
    localparam int SETTLE = 150;
    localparam int IN_BITS = $bits(t_in_item);

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;
    int          fail_count;
    int          pending;
    int          results_taken;
    bit          no_idle;

    fcsm_if #(.T(t_in_item))  req_ch ();
    fcsm_if #(.T(t_out_item)) res_ch ();

    four_channel_sample_mixer DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .in_if       (req_ch.sink),
        .out_if      (res_ch.source)
    );

    fcsm_mix_checker mix_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_req_valid  (req_ch.valid),
        .i_req_ready  (req_ch.ready),
        .i_req        (req_ch.payload),
        .i_res_valid  (res_ch.valid),
        .i_res_ready  (res_ch.ready),
        .i_res        (res_ch.payload),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Fill every field at random, then fix the action; callers override what matters.
    function automatic t_in_item blank_item(logic [1:0] act);
        t_in_item it;
        it = IN_BITS'({$urandom, $urandom, $urandom});
        it.action = act;
        return it;
    endfunction

    function automatic t_in_item byte_item(int addr, int val);
        t_in_item it;
        it = blank_item(ACT_BYTE);
        it.mem_address = 16'(addr);
        it.mem_byte = 8'(val);
        return it;
    endfunction

    function automatic t_in_item instr_item(int slot, int base, int level, bit present);
        t_in_item it;
        it = blank_item(ACT_INSTR);
        it.instrument_slot = 4'(slot);
        it.instrument_base = 16'(base);
        it.instrument_level = 7'(level);
        it.instrument_present = present;
        return it;
    endfunction

    function automatic t_in_item note_item(int v, int note, int eff);
        t_in_item it;
        it = blank_item(ACT_NOTE);
        it.voice = 2'(v);
        it.note_word = 16'(note);
        it.effect_word = 16'(eff);
        return it;
    endfunction

    // Mostly note starts and frames on well-formed instruments, with some noise:
    // stray byte writes, absent or out-of-range instruments, odd note codes.
    function automatic t_in_item random_item();
        int       pick, blk, sel;
        t_in_item it;
        pick = $urandom_range(0, 99);
        blk = $urandom_range(0, NUM_BLOCKS - 1);
        if (pick < 8) begin
            // keep header bytes intact: write data bytes or memory outside the region
            if ($urandom_range(0, 1))
                it = byte_item(blk * BLOCK_SPAN + $urandom_range(DATA_FIRST, BLOCK_SPAN - 1),
                               $urandom_range(0, 255));
            else
                it = byte_item($urandom_range(REGION_END, 16'hFFFF), $urandom_range(0, 255));
        end else if (pick < 11) begin
            // rewrite a length or loop length, low byte only
            if ($urandom_range(0, 1))
                it = byte_item(blk * BLOCK_SPAN + 1, $urandom_range(0, 4));
            else
                it = byte_item(blk * BLOCK_SPAN + 3, $urandom_range(0, 3));
        end else if (pick < 19) begin
            it = instr_item($urandom_range(0, 15), 0, $urandom_range(0, 127),
                            $urandom_range(0, 3) != 0);
            // a present instrument must point at a block; absent ones may point anywhere
            it.instrument_base = 16'((it.instrument_present
                                      && it.instrument_slot < NUM_INSTRUMENTS_DEF)
                               ? blk * BLOCK_SPAN : $urandom_range(0, 16'hFFFF));
        end else if (pick < 50) begin
            it = note_item($urandom_range(0, 3), $urandom_range(PERIOD_MIN, PERIOD_END - 1),
                           $urandom_range(0, 16'hFFFF));
            sel = $urandom_range(0, 9);
            case (sel)
                0: it.note_word = 16'd0;
                1: it.note_word = NOTE_MARK;
                2: it.note_word = NOTE_STOP;
                3: it.note_word = 16'($urandom_range(1, PERIOD_MIN - 1));
                4: it.note_word = 16'($urandom_range(PERIOD_END, NOTE_MARK - 1));
                default: ;
            endcase
            sel = $urandom_range(0, 9);
            if (sel < 4) it.effect_word[11:8] = EFF_VOL_UP;
            else if (sel < 7) it.effect_word[11:8] = EFF_VOL_DN;
        end else begin
            it = blank_item(ACT_FRAME);
        end
        return it;
    endfunction

    // Offer one item and hold it until taken; valid is left high so a back-to-back
    // item never lowers and raises it within one step.
    task automatic send_item(t_in_item it);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.payload <= it;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
    endtask

    // Drop valid and wait until every predicted item has come back.
    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_rate(int rate);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= 16'(rate);
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_random(int count);
        repeat (count) send_item(random_item());
    endtask

    // Result side: random hold-offs, plus one long stall so the block backs up.
    initial begin : result_taker
        int hold;
        res_ch.ready = 1'b0;
        results_taken = 0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            hold = no_idle ? 0 : $urandom_range(0, 5);
            if (results_taken == 420) hold = 300;
            if (hold > 0) begin
                res_ch.ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!res_ch.valid) @(posedge i_clk);
            results_taken++;
        end
    end

    initial begin
        int lenw, loopw;
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        req_ch.valid = 1'b0;
        req_ch.payload = '0;
        no_idle = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Load the blocks: block 0 is a short one-shot, block 1 loops, block 7 is empty.
        for (int k = 0; k < NUM_BLOCKS; k++) begin
            lenw = (k == 0) ? 4 : (k == 1) ? 3 : (k == 7) ? 0 : $urandom_range(1, 4);
            loopw = (k == 0) ? 0 : (k == 1) ? 2 : $urandom_range(0, 3);
            send_item(byte_item(k * BLOCK_SPAN + 0, 0));
            send_item(byte_item(k * BLOCK_SPAN + 1, lenw));
            send_item(byte_item(k * BLOCK_SPAN + 2, 0));
            send_item(byte_item(k * BLOCK_SPAN + 3, loopw));
            for (int a = DATA_FIRST; a < BLOCK_SPAN; a++)
                send_item(byte_item(k * BLOCK_SPAN + a, $urandom_range(0, 255)));
        end

        // Directed part at the reset rate.
        send_item(byte_item(DATA_FIRST + 0, 8'h80));
        send_item(byte_item(DATA_FIRST + 1, 8'h7F));
        send_item(byte_item(DATA_FIRST + 2, 8'hFF));
        send_item(byte_item(16'hFFFF, 8'hFF));
        send_item(instr_item(0, 0, 64, 1));
        send_item(instr_item(14, BLOCK_SPAN, 127, 1));        // level saturates at 64
        send_item(instr_item(15, 16'hFFFF, 127, 1));          // slot out of range: ignored
        send_item(instr_item(1, 16'hFFFF, 0, 0));             // absent instrument
        send_item(note_item(0, PERIOD_MIN, 16'h1000));
        send_item(note_item(1, PERIOD_END - 1, 16'hF5FF));    // volume up, clamped
        send_item(note_item(2, 16'h0200, 16'h2000));          // absent: no start
        send_item(note_item(3, PERIOD_MIN - 1, 16'h16FF));    // volume down to zero, no start
        send_item(note_item(3, PERIOD_END, 16'h1000));        // period too long
        send_item(note_item(3, 16'h0100, 16'h1520));
        send_item(note_item(2, NOTE_MARK, 16'hFFFF));
        send_item(note_item(2, 0, 16'h0000));
        send_item(note_item(1, 0, 16'h1000));                 // volume only
        repeat (4) send_item(blank_item(ACT_FRAME));
        send_item(note_item(0, NOTE_STOP, 16'h0000));
        repeat (3) send_item(blank_item(ACT_FRAME));

        // Zero rate divides by one: start a one-shot, let it run out, then stop it.
        set_rate(0);
        send_item(note_item(0, 16'h0100, 16'h1000));
        repeat (2) send_item(blank_item(ACT_FRAME));
        send_item(note_item(0, NOTE_STOP, 16'h0000));

        set_rate(4000);
        run_random(110);
        set_rate(16'hFFFF);
        no_idle = 1;
        run_random(60);
        drain();
        no_idle = 0;
        set_rate($urandom_range(4000, 16'hFFFF));
        run_random(150);

        drain();
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #(12 * 2000000);
        $display("CHECKS FAILED");
        $finish;
    end
endmodule
